>>> src/cobs_pkg.sv
// ----------------------------------------------------------------------------
// cobs_pkg: shared definitions of the COBS frame encoder
// Default frame length, the delimiter constant, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cobs_pkg;

    // Default number of payload bytes in one frame.
    localparam int FRAME_BYTES_DEFAULT = 16;

    // The byte that ends every encoded frame.
    localparam logic [7:0] DELIM_BYTE = 8'h00;

    // Source of the next encoded byte.
    typedef enum logic [1:0] {
        SEL_CODE  = 2'd0,
        SEL_DATA  = 2'd1,
        SEL_DELIM = 2'd2
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;   // an input beat is taken this cycle
        logic     load;     // load the output register
        out_sel_t sel;      // what the output register loads
        logic     last;     // the loaded byte ends the results of its input
        logic     rd_clr;   // rewind the run read pointer
        logic     rd_inc;   // advance the run read pointer
        logic     run_clr;  // the open run has been sent; empty it
    } cobs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;    // the next input beat is the last of its frame
        logic byte_zero;    // the offered input byte is zero
        logic run_empty;    // no bytes held in the open run
        logic rd_last;      // read pointer is at the last byte of the run
        logic out_free;     // output register can take a byte this cycle
    } cobs_status_t;

endpackage

>>> src/cobs_ctrl.sv
// ----------------------------------------------------------------------------
// cobs_ctrl: sequencing controller of the COBS frame encoder
// Takes input beats, then walks each run flush (code byte, stuffed bytes)
// and the frame delimiter, one output byte per free output slot.
// ----------------------------------------------------------------------------
module cobs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cobs_pkg::cobs_status_t status,
    output cobs_pkg::cobs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CODE,
        ST_DATA,
        ST_DELIM
    } state_t;

    state_t state_reg, state_next;
    logic   end_pend_reg, end_pend_next;      // end-of-frame flush still to start
    logic   delim_pend_reg, delim_pend_next;  // delimiter follows the current flush
    logic   more_after;

    // Results still follow once the current flush is done.
    assign more_after = end_pend_reg || delim_pend_reg;

    // State and pending flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            end_pend_reg   <= 1'b0;
            delim_pend_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            end_pend_reg   <= end_pend_next;
            delim_pend_reg <= delim_pend_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next      = state_reg;
        end_pend_next   = end_pend_reg;
        delim_pend_next = delim_pend_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.sel         = cobs_pkg::SEL_CODE;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.byte_zero) begin
                        state_next      = ST_CODE;
                        end_pend_next   = status.frame_end;
                        delim_pend_next = 1'b0;
                    end else if (status.frame_end) begin
                        state_next      = ST_CODE;
                        end_pend_next   = 1'b0;
                        delim_pend_next = 1'b1;
                    end
                end
            end

            ST_CODE: begin
                cmd.rd_clr = 1'b1;
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = cobs_pkg::SEL_CODE;
                    cmd.last = status.run_empty && !more_after;
                    if (status.run_empty) begin
                        cmd.run_clr = 1'b1;
                        if (end_pend_reg) begin
                            end_pend_next   = 1'b0;
                            delim_pend_next = 1'b1;
                        end else if (delim_pend_reg) begin
                            state_next = ST_DELIM;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end

            ST_DATA: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = cobs_pkg::SEL_DATA;
                    cmd.rd_inc = 1'b1;
                    cmd.last   = status.rd_last && !more_after;
                    if (status.rd_last) begin
                        cmd.run_clr = 1'b1;
                        if (end_pend_reg) begin
                            state_next      = ST_CODE;
                            end_pend_next   = 1'b0;
                            delim_pend_next = 1'b1;
                        end else if (delim_pend_reg) begin
                            state_next = ST_DELIM;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_DELIM: begin
                if (status.out_free) begin
                    cmd.load        = 1'b1;
                    cmd.sel         = cobs_pkg::SEL_DELIM;
                    cmd.last        = 1'b1;
                    delim_pend_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/cobs_datapath.sv
// ----------------------------------------------------------------------------
// cobs_datapath: run buffer, counters and output register of the encoder
// Holds the nonzero bytes of the open run in a small memory, counts the
// run length and the frame position, and drives the result channel.
// ----------------------------------------------------------------------------
module cobs_datapath #(
    parameter int FRAME_BYTES = cobs_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_data_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run,
    output logic                  m_is_delimiter,
    input  cobs_pkg::cobs_cmd_t    cmd,
    output cobs_pkg::cobs_status_t status
);

    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(FRAME_BYTES);

    logic [7:0]       run_mem [FRAME_BYTES];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg;
    logic             last_reg;
    logic             delim_reg;
    logic             byte_zero;
    logic [7:0]       load_byte;

    assign byte_zero = (s_data_byte == 8'h00);

    // Status toward the controller.
    assign status.frame_end = (pos_reg == POS_LAST);
    assign status.byte_zero = byte_zero;
    assign status.run_empty = (run_len_reg == '0);
    assign status.rd_last   = ((CNT_W'(rd_ptr_reg) + CNT_W'(1)) == run_len_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    // Run length and frame position counters.
    always_comb begin
        run_len_next = run_len_reg;
        pos_next     = pos_reg;
        if (cmd.accept) begin
            if (!byte_zero) begin
                run_len_next = run_len_reg + CNT_W'(1);
            end
            if (status.frame_end) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + IDX_W'(1);
            end
        end
        if (cmd.run_clr) begin
            run_len_next = '0;
        end
    end

    // Read pointer; the memory reads at the next pointer so that the
    // registered read data always matches the current pointer.
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.rd_clr) begin
            rd_ptr_next = '0;
        end else if (cmd.rd_inc) begin
            rd_ptr_next = rd_ptr_reg + IDX_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            pos_reg     <= '0;
            rd_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            run_len_reg <= run_len_next;
            pos_reg     <= pos_next;
            rd_ptr_reg  <= rd_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Run buffer memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.accept && !byte_zero) begin
            run_mem[run_len_reg[IDX_W-1:0]] <= s_data_byte;
        end
        rd_data_reg <= run_mem[rd_ptr_next];
    end

    // Byte selected for the output register.
    always_comb begin
        case (cmd.sel)
            cobs_pkg::SEL_CODE:  load_byte = 8'(run_len_reg) + 8'd1;
            cobs_pkg::SEL_DATA:  load_byte = rd_data_reg;
            cobs_pkg::SEL_DELIM: load_byte = cobs_pkg::DELIM_BYTE;
            default:             load_byte = cobs_pkg::DELIM_BYTE;
        endcase
    end

    // Output register: a beat stays until the consumer takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_byte_reg <= load_byte;
            last_reg     <= cmd.last;
            delim_reg    <= (cmd.sel == cobs_pkg::SEL_DELIM);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_last_of_run  = last_reg;
    assign m_is_delimiter = delim_reg;

    // The delimiter is a zero byte and always closes its input's results.
    a_delim_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && delim_reg) |-> (out_byte_reg == 8'h00 && last_reg))
        else $error("delimiter beat is not a final zero byte");

    // The open run never holds more bytes than a frame.
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= CNT_MAX)
        else $error("run length exceeds the frame length");

    // A waiting output beat is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && m_valid_reg && !m_ready))
        else $error("output register loaded while its beat is stalled");

    // The frame counter restarts after the last byte of a frame.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.frame_end) |=> (pos_reg == '0))
        else $error("frame position did not restart at the frame end");

endmodule

>>> src/cobs_frame_encoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_encoder: streaming COBS encoder for fixed-length frames
// Encodes each frame of FRAME_BYTES payload bytes with consistent overhead
// byte stuffing and ends it with a zero delimiter.
//
//   Channel   Ports                                    Direction  Beat
//   s_        s_valid s_ready s_data_byte              in         payload byte
//   m_        m_valid m_ready m_out_byte               out        encoded byte
//             m_last_of_run m_is_delimiter
//
// A nonzero byte inside a frame is taken and gives no result. A byte that
// causes results holds the input while the controller sends them, one byte
// per cycle while output is free; run bytes come from the buffer's read port.
// A stalled m_ready holds the output register and pauses the sequencer.
// Reset (aresetn low, synchronous) empties the run and restarts the frame.
// ----------------------------------------------------------------------------
module cobs_frame_encoder #(
    parameter int FRAME_BYTES = cobs_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_is_delimiter
);

    cobs_pkg::cobs_cmd_t    cmd;
    cobs_pkg::cobs_status_t status;

    // Sequencer.
    cobs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Run buffer, counters and output register.
    cobs_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_is_delimiter (m_is_delimiter),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
